>>> rtl/gap_buffer_with_line_count_top_macros.svh
// Assertion macros for the gap buffer top level.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef GAP_BUFFER_WITH_LINE_COUNT_TOP_MACROS_SVH
`define GAP_BUFFER_WITH_LINE_COUNT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gbl_pkg.sv
// Shared constants, types and helpers for the gap buffer block.
// No dependencies; used by the interfaces, the engine and the top level.
package gbl_pkg;

    localparam int BLOCK_CHARS = 4096;
    localparam int ADDR_W      = $clog2(BLOCK_CHARS);
    localparam int CNT_W       = $clog2(BLOCK_CHARS + 1);
    localparam int FIELD_W     = 13;
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int CMP_W       = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [CMP_W-1:0]   t_cmp;

    typedef enum logic [KIND_W-1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NOP    = 2'd3
    } t_req_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_BAD_OFFSET = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_OVERRUN    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RDATA,
        S_MOVE,
        S_INSERT,
        S_COUNT,
        S_DONE
    } t_eng_state;

    typedef struct packed {
        t_req_kind kind;
        t_field    offset;
        t_char     char_in;
        t_field    amount;
    } t_req;

    typedef struct packed {
        t_char   char_out;
        t_status status;
        t_field  text_length;
        t_field  line_count;
    } t_rsp;

    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_char wr_data;
    } t_mem_cmd;

    typedef struct packed {
        logic idle;
        t_cnt gap_start;
        t_cnt gap_size;
    } t_eng_mon;

    function automatic t_field cnt_to_field(input t_cnt v);
        logic [CNT_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    function automatic t_cnt field_to_cnt(input t_field v);
        logic [CNT_W+FIELD_W-1:0] w;
        w = {{CNT_W{1'b0}}, v};
        return w[CNT_W-1:0];
    endfunction

    function automatic t_cmp cnt_to_cmp(input t_cnt v);
        logic [CNT_W+CMP_W-1:0] w;
        w = {{CMP_W{1'b0}}, v};
        return w[CMP_W-1:0];
    endfunction

    function automatic t_cmp field_to_cmp(input t_field v);
        logic [FIELD_W+CMP_W-1:0] w;
        w = {{CMP_W{1'b0}}, v};
        return w[CMP_W-1:0];
    endfunction

    function automatic t_addr cnt_to_addr(input t_cnt v);
        return v[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/gbl_req_if.sv
// Request channel: valid/ready handshake with one request payload.
// Depends on gbl_pkg for field widths.
interface gbl_req_if;
    import gbl_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  req_type;
    logic [FIELD_W-1:0] offset;
    logic [CHAR_W-1:0]  char_in;
    logic [FIELD_W-1:0] amount;

    modport source (output valid, req_type, offset, char_in, amount, input ready);
    modport sink   (input valid, req_type, offset, char_in, amount, output ready);
endinterface

>>> rtl/gbl_rsp_if.sv
// Response channel: valid/ready handshake with one reply payload.
// Depends on gbl_pkg for field widths.
interface gbl_rsp_if;
    import gbl_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  char_out;
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] line_count;

    modport source (output valid, char_out, status, text_length, line_count, input ready);
    modport sink   (input valid, char_out, status, text_length, line_count, output ready);
endinterface

>>> rtl/gbl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/gbl_engine.sv
// Request sequencer: range checks, gap moves, insert write and newline scan.
// Depends on gbl_pkg; drives the text RAM through a t_mem_cmd struct.
module gbl_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  gbl_pkg::t_req     i_req,
    output logic              o_res_valid,
    input  logic              i_res_taken,
    output gbl_pkg::t_rsp     o_res,
    output gbl_pkg::t_mem_cmd o_mem,
    input  gbl_pkg::t_char    i_rd_data,
    output gbl_pkg::t_eng_mon o_mon
);
    import gbl_pkg::*;

    t_eng_state r_state, n_state;
    t_req       r_req, n_req;
    t_cnt       r_gs, n_gs;
    t_cnt       r_gz, n_gz;
    t_cnt       r_lines, n_lines;
    t_cnt       r_target, n_target;
    t_cnt       r_left, n_left;
    t_cnt       r_src, n_src;
    logic       r_pend, n_pend;
    t_addr      r_wr_addr, n_wr_addr;
    t_char      r_char, n_char;
    t_status    r_status, n_status;

    t_cnt c_len;
    t_cmp c_len_cmp;
    t_cmp c_off_cmp;
    t_cmp c_end_cmp;
    t_cnt c_off_cnt;
    t_cnt c_amt_cnt;

    assign c_len     = t_cnt'(BLOCK_CHARS) - r_gz;
    assign c_len_cmp = cnt_to_cmp(c_len);
    assign c_off_cmp = field_to_cmp(r_req.offset);
    assign c_end_cmp = c_off_cmp + field_to_cmp(r_req.amount);
    assign c_off_cnt = field_to_cnt(r_req.offset);
    assign c_amt_cnt = field_to_cnt(r_req.amount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gs    <= '0;
            r_gz    <= t_cnt'(BLOCK_CHARS);
            r_lines <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_gz    <= n_gz;
            r_lines <= n_lines;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_target  <= n_target;
        r_left    <= n_left;
        r_src     <= n_src;
        r_wr_addr <= n_wr_addr;
        r_char    <= n_char;
        r_status  <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_gs        = r_gs;
        n_gz        = r_gz;
        n_lines     = r_lines;
        n_target    = r_target;
        n_left      = r_left;
        n_src       = r_src;
        n_pend      = r_pend;
        n_wr_addr   = r_wr_addr;
        n_char      = r_char;
        n_status    = r_status;
        o_mem       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_char   = '0;
                n_status = STAT_OK;
                n_pend   = 1'b0;
                case (r_req.kind)
                    REQ_READ: begin
                        if (c_off_cmp >= c_len_cmp) begin
                            n_status = STAT_BAD_OFFSET;
                            n_state  = S_DONE;
                        end else begin
                            // Skip over the gap for offsets at or past its start
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = (c_off_cnt < r_gs) ? cnt_to_addr(c_off_cnt)
                                                               : cnt_to_addr(c_off_cnt + r_gz);
                            n_state       = S_RDATA;
                        end
                    end
                    REQ_INSERT: begin
                        if (c_off_cmp > c_len_cmp) begin
                            n_status = STAT_BAD_OFFSET;
                            n_state  = S_DONE;
                        end else if (r_gz == '0) begin
                            n_status = STAT_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_target = c_off_cnt;
                            n_state  = S_MOVE;
                        end
                    end
                    REQ_REMOVE: begin
                        if (c_off_cmp > c_len_cmp) begin
                            n_status = STAT_BAD_OFFSET;
                            n_state  = S_DONE;
                        end else if (c_end_cmp > c_len_cmp) begin
                            n_status = STAT_OVERRUN;
                            n_state  = S_DONE;
                        end else begin
                            n_target = c_off_cnt;
                            n_state  = S_MOVE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDATA: begin
                n_char  = i_rd_data;
                n_state = S_DONE;
            end
            S_MOVE: begin
                // Retire the character read last cycle
                if (r_pend) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_wr_addr;
                    o_mem.wr_data = i_rd_data;
                end
                if (r_gs < r_target) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = cnt_to_addr(r_gs + r_gz);
                    n_wr_addr     = cnt_to_addr(r_gs);
                    n_gs          = r_gs + t_cnt'(1);
                    n_pend        = 1'b1;
                end else if (r_gs > r_target) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = cnt_to_addr(r_gs - t_cnt'(1));
                    n_wr_addr     = cnt_to_addr(r_gs - t_cnt'(1) + r_gz);
                    n_gs          = r_gs - t_cnt'(1);
                    n_pend        = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_req.kind == REQ_INSERT) begin
                            n_state = S_INSERT;
                        end else begin
                            n_left  = c_amt_cnt;
                            n_src   = r_gs + r_gz;
                            n_state = S_COUNT;
                        end
                    end
                end
            end
            S_INSERT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = cnt_to_addr(r_gs);
                o_mem.wr_data = r_req.char_in;
                n_gs          = r_gs + t_cnt'(1);
                n_gz          = r_gz - t_cnt'(1);
                if (r_req.char_in == NEWLINE_CHAR) begin
                    n_lines = r_lines + t_cnt'(1);
                end
                n_state = S_DONE;
            end
            S_COUNT: begin
                // Scan the characters that the gap is about to absorb
                if (r_pend && (i_rd_data == NEWLINE_CHAR)) begin
                    n_lines = r_lines - t_cnt'(1);
                end
                if (r_left != '0) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = cnt_to_addr(r_src);
                    n_src         = r_src + t_cnt'(1);
                    n_left        = r_left - t_cnt'(1);
                    n_pend        = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_gz    = r_gz + c_amt_cnt;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.char_out    = r_char;
    assign o_res.status      = r_status;
    assign o_res.text_length = cnt_to_field(c_len);
    assign o_res.line_count  = cnt_to_field(r_lines);

    assign o_mon.idle      = (r_state == S_IDLE);
    assign o_mon.gap_start = r_gs;
    assign o_mon.gap_size  = r_gz;
endmodule

>>> rtl/gap_buffer_with_line_count_top.sv
// Top level of the gap buffer text block with newline count.
// Depends on gbl_pkg, gbl_req_if, gbl_rsp_if, gbl_ram, gbl_engine and the macro header.
//
//   channel   direction   transaction
//   i_req     in          one request: req_type, offset, char_in, amount
//   o_rsp     out         one reply: char_out, status, text_length, line_count
//
// A request is checked first; a read then fetches its character, an insert moves
// the gap to the offset and writes the character, and a remove moves the gap
// and scans the characters that it absorbs for newlines before the reply is
// offered. The single text RAM moves or scans one character per cycle, and the
// next request is taken once the current reply is handed off.
// Reset: synchronous, active low; gap, length and line count clear at once. The
// text RAM is not cleared, since no entry is read before it is written.
// Stalls: a held reply waits in the output register while the engine goes on.
`include "gap_buffer_with_line_count_top_macros.svh"

module gap_buffer_with_line_count_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbl_req_if.sink   i_req,
    gbl_rsp_if.source o_rsp
);
    import gbl_pkg::*;

    t_req     req_bus;
    t_rsp     eng_res;
    logic     eng_res_valid;
    logic     eng_ready;
    logic     eng_taken;
    t_mem_cmd mem_cmd;
    t_char    mem_rd_data;
    t_eng_mon eng_mon;

    logic r_out_valid;
    t_rsp r_out;

    logic                 gap_fits;
    logic [2*CNT_W-1:0]   gap_pair;
    logic                 eng_failed;

    // Pack the request transaction for the engine
    assign req_bus.kind    = t_req_kind'(i_req.req_type);
    assign req_bus.offset  = i_req.offset;
    assign req_bus.char_in = i_req.char_in;
    assign req_bus.amount  = i_req.amount;
    assign i_req.ready     = eng_ready;

    gbl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (eng_ready),
        .i_req       (req_bus),
        .o_res_valid (eng_res_valid),
        .i_res_taken (eng_taken),
        .o_res       (eng_res),
        .o_mem       (mem_cmd),
        .i_rd_data   (mem_rd_data),
        .o_mon       (eng_mon)
    );

    // Text store: one write and one read per cycle
    gbl_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BLOCK_CHARS)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_cmd.wr_en),
        .i_wr_addr (mem_cmd.wr_addr),
        .i_wr_data (mem_cmd.wr_data),
        .i_rd_en   (mem_cmd.rd_en),
        .i_rd_addr (mem_cmd.rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Hand the reply to the output register when it is empty or draining
    assign eng_taken = eng_res_valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_taken) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_taken) begin
            r_out <= eng_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.char_out    = r_out.char_out;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.text_length = r_out.text_length;
    assign o_rsp.line_count  = r_out.line_count;

    // Terms for the checks below
    assign gap_fits   = (cnt_to_cmp(eng_mon.gap_start) + cnt_to_cmp(eng_mon.gap_size))
                        <= t_cmp'(BLOCK_CHARS);
    assign gap_pair   = {eng_mon.gap_start, eng_mon.gap_size};
    assign eng_failed = eng_res_valid && (eng_res.status != STAT_OK);

    // The gap never runs past the end of the store
    `GBL_ASSERT_NOW(a_gap_in_store, 1'b1, gap_fits, "gap extends past end of text store")
    // No store write while waiting for a request
    `GBL_ASSERT_NOW(a_idle_no_write, eng_mon.idle, !mem_cmd.wr_en, "store written while idle")
    // Gap position and size hold across an idle cycle
    `GBL_ASSERT_NEXT(a_idle_gap_hold, eng_mon.idle, $stable(gap_pair), "gap moved while idle")
    // A failed request carries no character
    `GBL_ASSERT_NOW(a_fail_no_char, eng_failed, eng_res.char_out == '0, "failed reply has a char")
endmodule
